// ===== rtl/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the cache RTL. Clock clk_i, reset rst_ni assumed in scope.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Property that must hold on every clock outside reset.
`define LKVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent in the next cycle.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CapW    = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

endpackage

// ===== rtl/lkvc_if.sv =====
interface lkvc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [lkvc_pkg::KeyW-1:0] key;
  logic signed [lkvc_pkg::ValW-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [lkvc_pkg::ValW-1:0] read_value;
  logic                             evicted;
  logic signed [lkvc_pkg::KeyW-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// ===== rtl/lru_key_value_cache.sv =====
// Requests pass through an input register and a result register; a response is registered
// when its request executes. Throughput: one request per cycle while responses are taken;
// the key compare and the rank update of all entries happen together. A held response stalls input.
// Reset clears valid bits, recency ranks and fill count and sets capacity to 16;
// key and value stores are not reset.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = lkvc_pkg::Entries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]   cfg_wdata_i,
  lkvc_req_if.sink                    req_i,
  lkvc_rsp_if.source                  rsp_o
);

  localparam int unsigned RankW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > lkvc_pkg::CapW) ? CntW : lkvc_pkg::CapW;
  localparam int unsigned KeyW  = lkvc_pkg::KeyW;
  localparam int unsigned ValW  = lkvc_pkg::ValW;

  logic [lkvc_pkg::CapW-1:0] cap_q;

  // input register
  logic            in_vld_q;
  logic            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  // entry state
  logic [ENTRIES-1:0] valid_q;
  logic [RankW-1:0]   rank_q  [ENTRIES];
  logic [CntW-1:0]    fill_q;
  logic [KeyW-1:0]    key_mem [ENTRIES];
  logic [ValW-1:0]    val_mem [ENTRIES];

  // result register
  logic            out_vld_q;
  logic            hit_q;
  logic [ValW-1:0] rd_q;
  logic            ev_q;
  logic [KeyW-1:0] evk_q;

  logic               advance;
  logic               exec;
  logic               is_put;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] match_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] lru_vec;
  logic [ENTRIES-1:0] sel_oh;
  logic               hit;
  logic               room;
  logic               evict;
  logic [RankW-1:0]   oldest_rank;
  logic [RankW-1:0]   hit_rank;
  logic [ValW-1:0]    hit_val;
  logic [KeyW-1:0]    lru_key;
  logic [CntW-1:0]    old_rank;
  logic [CmpW-1:0]    eff_cap;
  logic               update;

  assign advance     = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;
  assign exec        = in_vld_q && advance;
  assign is_put      = (cmd_q == lkvc_pkg::CMD_PUT);

  assign oldest_rank = RankW'(fill_q - CntW'(1));

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    lru_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (key_mem[i] == key_q);
      lru_vec[i]   = valid_q[i] && (rank_q[i] == oldest_rank);
    end
    // keys are unique among valid entries; keep the lowest match anyway
    match_oh = match_vec & ((~match_vec) + ENTRIES'(1));
    free_oh  = (~valid_q) & (valid_q + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (match_oh[i] ? rank_q[i] : '0);
      hit_val  = hit_val  | (match_oh[i] ? val_mem[i] : '0);
      lru_key  = lru_key  | (lru_vec[i] ? key_mem[i] : '0);
    end
  end

  assign hit = |match_vec;

  always_comb begin
    eff_cap = CmpW'(cap_q);
    if (eff_cap == '0) begin
      eff_cap = CmpW'(1);
    end else if (eff_cap > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end
  end

  assign room = CmpW'(fill_q) < eff_cap;

  always_comb begin
    evict = 1'b0;
    priority if (hit) begin
      sel_oh   = match_oh;
      old_rank = CntW'(hit_rank);
    end else if (room) begin
      // new entry becomes the most recent one, so all valid entries age
      sel_oh   = free_oh;
      old_rank = fill_q;
    end else begin
      sel_oh   = lru_vec;
      old_rank = CntW'(oldest_rank);
      evict    = is_put;
    end
  end

  assign update = exec && (hit || is_put);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel_oh[i]) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (CntW'(rank_q[i]) < old_rank)) begin
          rank_q[i] <= rank_q[i] + RankW'(1);
        end
      end
      if (!hit && room) begin
        valid_q <= valid_q | sel_oh;
        fill_q  <= fill_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (exec && is_put && sel_oh[i]) begin
        val_mem[i] <= val_q;
        if (!hit) begin
          key_mem[i] <= key_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      hit_q <= hit;
      rd_q  <= (hit && !is_put) ? hit_val : '0;
      ev_q  <= evict;
      evk_q <= evict ? lru_key : '0;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.read_value  = rd_q;
  assign rsp_o.evicted     = ev_q;
  assign rsp_o.evicted_key = evk_q;

  `LKVC_ASSERT(a_fill_matches_valid, $countones(valid_q) == fill_q, "fill count out of step with valid bits")
  `LKVC_ASSERT(a_evict_is_miss, !(out_vld_q && ev_q && hit_q), "response reports both hit and eviction")
  `LKVC_ASSERT_NEXT(a_hit_keeps_fill, exec && hit, fill_q == $past(fill_q), "hit changed fill count")
  `LKVC_ASSERT_NEXT(a_evict_keeps_valid, exec && evict, valid_q == $past(valid_q), "eviction changed valid bits")

endmodule
